// ===== src/yhdg_pkg.sv =====
// ----------------------------------------------------------------------------
// yhdg_pkg
// Shared types, holiday codes and date helpers for the holiday date generator.
// ----------------------------------------------------------------------------
package yhdg_pkg;

  localparam int YEAR_W = 12;
  localparam int MON_W  = 4;
  localparam int DAY_W  = 5;
  localparam int ID_W   = 4;
  localparam int SET_W  = 2;

  localparam logic [SET_W-1:0] HSET_RESET = 2'd3;
  localparam int HSET_CIVIL = 0;
  localparam int HSET_RELIG = 1;

  // Holiday codes, in emission order
  localparam logic [ID_W-1:0] ID_NEW_YEAR   = 4'd0;
  localparam logic [ID_W-1:0] ID_LABOR      = 4'd1;
  localparam logic [ID_W-1:0] ID_VICTORY    = 4'd2;
  localparam logic [ID_W-1:0] ID_ARMISTICE  = 4'd3;
  localparam logic [ID_W-1:0] ID_NATIONAL   = 4'd4;
  localparam logic [ID_W-1:0] ID_ASSUMPTION = 4'd5;
  localparam logic [ID_W-1:0] ID_ALL_SAINTS = 4'd6;
  localparam logic [ID_W-1:0] ID_CHRISTMAS  = 4'd7;
  localparam logic [ID_W-1:0] ID_EASTER     = 4'd8;
  localparam logic [ID_W-1:0] ID_EASTER_1   = 4'd9;
  localparam logic [ID_W-1:0] ID_EASTER_39  = 4'd10;
  localparam logic [ID_W-1:0] ID_EASTER_49  = 4'd11;

  localparam logic [MON_W-1:0] MON_JAN = 4'd1;
  localparam logic [MON_W-1:0] MON_MAR = 4'd3;
  localparam logic [MON_W-1:0] MON_APR = 4'd4;
  localparam logic [MON_W-1:0] MON_MAY = 4'd5;
  localparam logic [MON_W-1:0] MON_JUN = 4'd6;
  localparam logic [MON_W-1:0] MON_JUL = 4'd7;
  localparam logic [MON_W-1:0] MON_AUG = 4'd8;
  localparam logic [MON_W-1:0] MON_NOV = 4'd11;
  localparam logic [MON_W-1:0] MON_DEC = 4'd12;

  typedef struct packed {
    logic [MON_W-1:0] month;
    logic [DAY_W-1:0] day;
  } date_t;

  // Easter Sunday and the three movable dates that follow it
  typedef struct packed {
    logic [YEAR_W-1:0] year;
    date_t [3:0]       dates;
  } easter_rec_t;

  // Fixed holidays, codes New Year through Christmas
  function automatic date_t fixed_date(input logic [ID_W-1:0] id);
    date_t r;
    unique case (id)
      ID_NEW_YEAR:   r = '{month: MON_JAN, day: 5'd1};
      ID_LABOR:      r = '{month: MON_MAY, day: 5'd1};
      ID_VICTORY:    r = '{month: MON_MAY, day: 5'd8};
      ID_ARMISTICE:  r = '{month: MON_NOV, day: 5'd11};
      ID_NATIONAL:   r = '{month: MON_JUL, day: 5'd14};
      ID_ASSUMPTION: r = '{month: MON_AUG, day: 5'd15};
      ID_ALL_SAINTS: r = '{month: MON_NOV, day: 5'd1};
      ID_CHRISTMAS:  r = '{month: MON_DEC, day: 5'd25};
      default:       r = '{month: MON_JAN, day: 5'd1};
    endcase
    return r;
  endfunction

  // Convert a day count where 1 is March 1 into a calendar date (March..June)
  function automatic date_t march_date(input logic [6:0] t);
    date_t r;
    priority if (t <= 7'd31) begin
      r = '{month: MON_MAR, day: t[4:0]};
    end else if (t <= 7'd61) begin
      r = '{month: MON_APR, day: DAY_W'(t - 7'd31)};
    end else if (t <= 7'd92) begin
      r = '{month: MON_MAY, day: DAY_W'(t - 7'd61)};
    end else begin
      r = '{month: MON_JUN, day: DAY_W'(t - 7'd92)};
    end
    return r;
  endfunction

endpackage

// ===== src/yearly_holiday_date_generator_core.sv =====
// ----------------------------------------------------------------------------
// yearly_holiday_date_generator_core
// Takes one year per word and emits that year's holiday dates in fixed order.
//
//   channel  ports                                        handshake
//   input    in_year                                      start, busy
//   result   out_year out_month out_day                   out_valid strobe
//            out_holiday_id out_last
//   config   cfg_holiday_set                              cfg_we
//
// A year passes a seven-stage computus pipeline, then a sequencer sends one
// date per cycle over the single result port: 1 to 12 dates per year, as
// set by the holiday set. Years may be started back to back; busy rises
// while the pipeline is backed up behind the sequencer. Synchronous
// active-low reset empties the pipeline and sets the holiday set to all
// enabled. The receiver takes every strobe.
// ----------------------------------------------------------------------------
module yearly_holiday_date_generator_core (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               start,
  output logic                               busy,
  input  logic [yhdg_pkg::YEAR_W-1:0]        in_year,
  output logic                               out_valid,
  output logic [yhdg_pkg::YEAR_W-1:0]        out_year,
  output logic [yhdg_pkg::MON_W-1:0]         out_month,
  output logic [yhdg_pkg::DAY_W-1:0]         out_day,
  output logic [yhdg_pkg::ID_W-1:0]          out_holiday_id,
  output logic                               out_last,
  input  logic                               cfg_we,
  input  logic [yhdg_pkg::SET_W-1:0]         cfg_holiday_set
);

  logic [yhdg_pkg::SET_W-1:0] hset_r;

  logic                  comp_ready;
  logic                  comp_valid;
  logic                  comp_in_ready;
  yhdg_pkg::easter_rec_t comp_rec;

  logic                          em_valid_r;
  logic [yhdg_pkg::ID_W-1:0]     em_id_r;
  logic [yhdg_pkg::ID_W-1:0]     em_id_nxt;
  yhdg_pkg::easter_rec_t         em_rec_r;
  logic                          em_last;
  yhdg_pkg::date_t               em_date;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hset_r <= yhdg_pkg::HSET_RESET;
    end else if (cfg_we) begin
      hset_r <= cfg_holiday_set;
    end
  end

  yhdg_computus u_computus (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (start),
    .in_ready  (comp_in_ready),
    .in_year   (in_year),
    .out_valid (comp_valid),
    .out_ready (comp_ready),
    .out_rec   (comp_rec)
  );

  assign busy = !comp_in_ready;

  // Next holiday code and end-of-run flag
  always_comb begin
    em_id_nxt = em_id_r + 4'd1;
    em_last   = 1'b0;
    priority if (em_id_r == yhdg_pkg::ID_NEW_YEAR) begin
      priority if (hset_r[yhdg_pkg::HSET_CIVIL]) begin
        em_id_nxt = yhdg_pkg::ID_LABOR;
      end else if (hset_r[yhdg_pkg::HSET_RELIG]) begin
        em_id_nxt = yhdg_pkg::ID_ASSUMPTION;
      end else begin
        em_last = 1'b1;
      end
    end else if (em_id_r == yhdg_pkg::ID_NATIONAL) begin
      em_last = !hset_r[yhdg_pkg::HSET_RELIG];
    end else if (em_id_r == yhdg_pkg::ID_EASTER_49) begin
      em_last = 1'b1;
    end else begin
      em_last = 1'b0;
    end
  end

  assign comp_ready = !em_valid_r || em_last;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      em_valid_r <= 1'b0;
      em_id_r    <= yhdg_pkg::ID_NEW_YEAR;
    end else if (comp_ready) begin
      em_valid_r <= comp_valid;
      em_id_r    <= yhdg_pkg::ID_NEW_YEAR;
    end else begin
      em_id_r <= em_id_nxt;
    end
  end

  // Hold the record for the whole run
  always_ff @(posedge clk) begin
    if (comp_ready) begin
      em_rec_r <= comp_rec;
    end
  end

  always_comb begin
    if (em_id_r < yhdg_pkg::ID_EASTER) begin
      em_date = yhdg_pkg::fixed_date(em_id_r);
    end else begin
      em_date = em_rec_r.dates[em_id_r[1:0]];
    end
  end

  assign out_valid      = em_valid_r;
  assign out_year       = em_rec_r.year;
  assign out_month      = em_date.month;
  assign out_day        = em_date.day;
  assign out_holiday_id = em_id_r;
  assign out_last       = em_last;

endmodule

// ===== src/yhdg_computus.sv =====
// ----------------------------------------------------------------------------
// yhdg_computus
// Seven-stage pipeline computing Easter Sunday and Easter +1, +39 and +49 days
// for one year per cycle while out_ready is high. Divisions by constants use reciprocals.
// ----------------------------------------------------------------------------
module yhdg_computus (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic [yhdg_pkg::YEAR_W-1:0]   in_year,
  output logic                          out_valid,
  input  logic                          out_ready,
  output yhdg_pkg::easter_rec_t         out_rec
);

  localparam int YW = yhdg_pkg::YEAR_W;

  logic v1_r, v2_r, v3_r, v4_r, v5_r, v6_r, v7_r;
  logic rdy1, rdy2, rdy3, rdy4, rdy5, rdy6, rdy7;

  // Stage 1: century and year/19 quotient
  logic [YW-1:0] y1_r;
  logic [5:0]    c1_r;
  logic [7:0]    q19_1_r;
  logic [22:0]   c_prod;
  logic [23:0]   q19_prod;

  // Stage 2: year mod 19, c/4, (8c+13)/25
  logic [YW-1:0] y2_r;
  logic [5:0]    c2_r;
  logic [4:0]    g2_r;
  logic [3:0]    c4_2_r;
  logic [4:0]    k2_r;
  logic [11:0]   g_full;
  logic [8:0]    k_num;
  logic [14:0]   k_prod;

  // Stage 3: epact sum and its quotient by 30
  logic [YW-1:0] y3_r;
  logic [5:0]    c3_r;
  logic [4:0]    g3_r;
  logic [8:0]    x3_r;
  logic [3:0]    q30_3_r;
  logic [9:0]    x_sum;
  logic [20:0]   q30_prod;

  // Stage 4: corrected epact
  logic [YW-1:0] y4_r;
  logic [5:0]    c4_r;
  logic [4:0]    ii4_r;
  logic [8:0]    h_full;
  logic [4:0]    h;
  logic [4:0]    ii;

  // Stage 5: weekday sum and its quotient by 7
  logic [YW-1:0] y5_r;
  logic [12:0]   s5_r;
  logic [9:0]    q7_5_r;
  logic [4:0]    ii5_r;
  logic [12:0]   s_sum;
  logic [26:0]   q7_prod;

  // Stage 6: days from March 22 to Easter
  logic [YW-1:0] y6_r;
  logic [5:0]    lp6_r;
  logic [12:0]   j_full;
  logic [5:0]    lp;

  // Stage 7: calendar dates
  logic [YW-1:0] y7_r;
  yhdg_pkg::date_t [3:0] d7_r;
  logic [6:0]    mday;

  assign rdy7     = !v7_r || out_ready;
  assign rdy6     = !v6_r || rdy7;
  assign rdy5     = !v5_r || rdy6;
  assign rdy4     = !v4_r || rdy5;
  assign rdy3     = !v3_r || rdy4;
  assign rdy2     = !v2_r || rdy3;
  assign rdy1     = !v1_r || rdy2;
  assign in_ready = rdy1;

  always_comb begin
    c_prod   = 23'(in_year) * 23'd1311;
    q19_prod = 24'(in_year) * 24'd3450;

    g_full = y1_r - 12'(q19_1_r) * 12'd19;
    k_num  = 9'(c1_r) * 9'd8 + 9'd13;
    k_prod = 15'(k_num) * 15'd41;

    x_sum    = 10'(c2_r) - 10'(c4_2_r) - 10'(k2_r) + 10'(g2_r) * 10'd19 + 10'd15;
    q30_prod = 21'(x_sum[8:0]) * 21'd2185;

    h_full = x3_r - 9'(q30_3_r) * 9'd30;
    h      = h_full[4:0];
    // Epact 29 maps to 28; epact 28 maps to 27 when year mod 19 exceeds 10
    priority if (h == 5'd29) begin
      ii = 5'd28;
    end else if (h == 5'd28 && g3_r > 5'd10) begin
      ii = 5'd27;
    end else begin
      ii = h;
    end

    s_sum   = 13'(y4_r) + 13'(y4_r >> 2) + 13'(ii4_r) + 13'd2
            + 13'(c4_r >> 2) - 13'(c4_r);
    q7_prod = 27'(s_sum) * 27'd9363;

    j_full = s5_r - 13'(q7_5_r) * 13'd7;
    lp     = 6'(ii5_r) + 6'd6 - 6'(j_full[2:0]);

    mday = 7'(lp6_r) + 7'd22;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
      v4_r <= 1'b0;
      v5_r <= 1'b0;
      v6_r <= 1'b0;
      v7_r <= 1'b0;
    end else begin
      if (rdy1) v1_r <= in_valid;
      if (rdy2) v2_r <= v1_r;
      if (rdy3) v3_r <= v2_r;
      if (rdy4) v4_r <= v3_r;
      if (rdy5) v5_r <= v4_r;
      if (rdy6) v6_r <= v5_r;
      if (rdy7) v7_r <= v6_r;
    end
  end

  always_ff @(posedge clk) begin
    if (rdy1) begin
      y1_r    <= in_year;
      c1_r    <= c_prod[22:17];
      q19_1_r <= q19_prod[23:16];
    end
    if (rdy2) begin
      y2_r   <= y1_r;
      c2_r   <= c1_r;
      g2_r   <= g_full[4:0];
      c4_2_r <= c1_r[5:2];
      k2_r   <= k_prod[14:10];
    end
    if (rdy3) begin
      y3_r    <= y2_r;
      c3_r    <= c2_r;
      g3_r    <= g2_r;
      x3_r    <= x_sum[8:0];
      q30_3_r <= q30_prod[19:16];
    end
    if (rdy4) begin
      y4_r  <= y3_r;
      c4_r  <= c3_r;
      ii4_r <= ii;
    end
    if (rdy5) begin
      y5_r   <= y4_r;
      s5_r   <= s_sum;
      q7_5_r <= q7_prod[25:16];
      ii5_r  <= ii4_r;
    end
    if (rdy6) begin
      y6_r  <= y5_r;
      lp6_r <= lp;
    end
    if (rdy7) begin
      y7_r    <= y6_r;
      d7_r[0] <= yhdg_pkg::march_date(mday);
      d7_r[1] <= yhdg_pkg::march_date(mday + 7'd1);
      d7_r[2] <= yhdg_pkg::march_date(mday + 7'd39);
      d7_r[3] <= yhdg_pkg::march_date(mday + 7'd49);
    end
  end

  assign out_valid     = v7_r;
  assign out_rec.year  = y7_r;
  assign out_rec.dates = d7_r;

endmodule
